### rtl/core/vibration_activity_detector_top_assert.svh
// Assertion macros used by the detector controller.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef VIBRATION_ACTIVITY_DETECTOR_TOP_ASSERT_SVH
`define VIBRATION_ACTIVITY_DETECTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vad assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VAD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vad assertion failed");

`endif

### rtl/core/vad_pkg.sv
package vad_pkg;

	localparam int AXES       = 3;
	localparam int ADC_W      = 10;
	localparam int GAIN_W     = 24;
	localparam int OFS_W      = 32;
	localparam int LEN_W      = 13;
	localparam int THR_W      = 16;
	localparam int HOLD_W     = 16;
	localparam int ACC_W      = 16;
	localparam int QC_W       = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_FIRST = axis_t'(0);
	localparam axis_t AXIS_LAST  = axis_t'(AXES - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0]        RST_GAIN   = 24'd65536;
	localparam logic signed [OFS_W-1:0]  RST_OFFSET = 32'sd0;
	localparam logic [LEN_W-1:0]         RST_LONG   = 13'd64;
	localparam logic [LEN_W-1:0]         RST_SHORT  = 13'd8;
	localparam logic [THR_W-1:0]         RST_THR    = 16'd10;
	localparam logic [HOLD_W-1:0]        RST_HOLD   = 16'd100;

	typedef struct packed {
		logic [GAIN_W-1:0]       gain;
		logic signed [OFS_W-1:0] offset;
		logic [LEN_W-1:0]        long_len;
		logic [LEN_W-1:0]        short_len;
		logic [THR_W-1:0]        thr;
		logic [HOLD_W-1:0]       hold;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load_in;
		logic  mul;
		logic  sat;
		logic  div_start;
		logic  div_step;
		logic  div_finish;
		logic  decide;
		axis_t axis;
		logic  sel_fast;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

### rtl/core/vad_dp.sv
module vad_dp import vad_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  cfg_t                         cfg,
	input  logic [ADC_W-1:0]             adc_x,
	input  logic [ADC_W-1:0]             adc_y,
	input  logic [ADC_W-1:0]             adc_z,
	output logic [AXES-1:0][ACC_W-1:0]   samp,
	output logic                         active
);

	localparam int PW = ADC_W + GAIN_W;
	localparam int DW = PW + 2;
	localparam int SW = DW - 16;
	localparam int CW = 4;

	logic [AXES-1:0][ADC_W-1:0] adc_q;
	logic [PW-1:0]              prod_q;
	logic [AXES-1:0][ACC_W-1:0] samp_q;
	logic [AXES-1:0][ACC_W-1:0] slow_q;
	logic [AXES-1:0][ACC_W-1:0] fast_q;
	logic [QC_W-1:0]            qc_q;
	logic                       active_q;

	logic [ACC_W-1:0]           dvd_q;
	logic [LEN_W-1:0]           rem_q;
	logic [LEN_W-1:0]           div_q;
	logic                       neg_q;
	logic [CW-1:0]              cnt_q;

	// Scaling: (adc * gain - offset) / 65536, rounding toward zero, saturated.
	logic signed [DW-1:0] diff;
	logic [DW-1:0]        mag;
	logic [SW-1:0]        shq;
	logic                 over;
	logic [ACC_W-1:0]     sat_val;

	assign diff = $signed({2'b00, prod_q})
		- $signed({{(DW-OFS_W){cfg.offset[OFS_W-1]}}, cfg.offset});
	assign mag  = diff[DW-1] ? (~diff + 1'b1) : diff;
	assign shq  = mag[DW-1:16];
	assign over = |shq[SW-1:ACC_W-1];

	always_comb begin
		if (diff[DW-1]) begin
			sat_val = over ? {1'b1, {(ACC_W-1){1'b0}}} : (~shq[ACC_W-1:0] + 1'b1);
		end else begin
			sat_val = over ? {1'b0, {(ACC_W-1){1'b1}}} : shq[ACC_W-1:0];
		end
	end

	// Averaging step operands.
	logic [ACC_W-1:0] avg_cur;
	logic [ACC_W:0]   dlt;
	logic [ACC_W:0]   dlt_mag;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] nlen;
	logic [LEN_W:0]   shifted;
	logic             ge;
	logic [ACC_W+1:0] new_avg;

	assign avg_cur = cmd.sel_fast ? fast_q[cmd.axis] : slow_q[cmd.axis];
	assign dlt     = {samp_q[cmd.axis][ACC_W-1], samp_q[cmd.axis]}
		- {avg_cur[ACC_W-1], avg_cur};
	assign dlt_mag = dlt[ACC_W] ? (~dlt + 1'b1) : dlt;
	assign len     = cmd.sel_fast ? cfg.short_len : cfg.long_len;
	assign nlen    = (len == '0) ? LEN_W'(1) : len;
	assign shifted = {rem_q, dvd_q[ACC_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign new_avg = {{2{avg_cur[ACC_W-1]}}, avg_cur}
		+ (neg_q ? (~{2'b00, dvd_q} + 1'b1) : {2'b00, dvd_q});

	assign sts.div_last = (cnt_q == {CW{1'b1}});

	// Activity decision from the updated averages.
	logic [AXES-1:0] hit_ax;
	logic [ACC_W:0]  ad [AXES];
	logic [ACC_W:0]  sd [AXES];
	logic [QC_W-1:0] hold1;
	logic [QC_W-1:0] qc_c;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			sd[i] = {slow_q[i][ACC_W-1], slow_q[i]} - {fast_q[i][ACC_W-1], fast_q[i]};
			ad[i] = sd[i][ACC_W] ? (~sd[i] + 1'b1) : sd[i];
			hit_ax[i] = ad[i] > {1'b0, cfg.thr};
		end
	end

	assign hold1 = {1'b0, cfg.hold} + 1'b1;
	assign qc_c  = (qc_q > hold1) ? hold1 : qc_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			adc_q <= {adc_z, adc_y, adc_x};
		end
		if (cmd.mul) begin
			prod_q <= adc_q[cmd.axis] * cfg.gain;
		end
		if (cmd.sat) begin
			samp_q[cmd.axis] <= sat_val;
		end
		if (cmd.div_start) begin
			dvd_q <= dlt_mag[ACC_W-1:0];
			rem_q <= '0;
			neg_q <= dlt[ACC_W];
			div_q <= nlen;
		end else if (cmd.div_step) begin
			rem_q <= ge ? LEN_W'(shifted - {1'b0, div_q}) : shifted[LEN_W-1:0];
			dvd_q <= {dvd_q[ACC_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			slow_q   <= '0;
			fast_q   <= '0;
			qc_q     <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.div_finish) begin
				if (cmd.sel_fast) begin
					fast_q[cmd.axis] <= new_avg[ACC_W-1:0];
				end else begin
					slow_q[cmd.axis] <= new_avg[ACC_W-1:0];
				end
			end
			if (cmd.decide) begin
				if (|hit_ax) begin
					qc_q     <= '0;
					active_q <= 1'b1;
				end else if (qc_c > {1'b0, cfg.hold}) begin
					qc_q     <= qc_c;
					active_q <= 1'b0;
				end else begin
					qc_q     <= qc_c + 1'b1;
					active_q <= 1'b1;
				end
			end
		end
	end

	assign samp   = samp_q;
	assign active = active_q;

endmodule

### rtl/core/vad_ctrl.sv
`include "vibration_activity_detector_top_assert.svh"

module vad_ctrl import vad_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_accept,
	input  logic out_free,
	input  sts_t sts,
	output cmd_t cmd,
	output logic idle,
	output logic out_load
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_SAT    = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DSTEP  = 3'd4;
	localparam logic [2:0] ST_DFIN   = 3'd5;
	localparam logic [2:0] ST_DECIDE = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0] state_q, state_d;
	axis_t      axis_q, axis_d;
	logic       sel_q, sel_d;

	always_comb begin
		state_d      = state_q;
		axis_d       = axis_q;
		sel_d        = sel_q;
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.sel_fast = sel_q;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DFIN;
				end
			end
			ST_DFIN: begin
				cmd.div_finish = 1'b1;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_DSTART;
				end else begin
					sel_d = 1'b0;
					if (axis_q == AXIS_LAST) begin
						axis_d  = AXIS_FIRST;
						state_d = ST_DECIDE;
					end else begin
						axis_d  = axis_q + 1'b1;
						state_d = ST_MUL;
					end
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				axis_d  = AXIS_FIRST;
				sel_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_FIRST;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			sel_q   <= sel_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

	`VAD_ASSERT_NXT(a_div_exit, state_q == ST_DSTEP && sts.div_last, state_q == ST_DFIN)
	`VAD_ASSERT_IMP(a_load_free, out_load, out_free && state_q == ST_DONE)
	`VAD_ASSERT_IMP(a_idle_clean, state_q == ST_IDLE, axis_q == AXIS_FIRST && !sel_q)
	`VAD_ASSERT_NXT(a_accept_starts, in_accept, state_q == ST_MUL)

endmodule

### rtl/core/vibration_activity_detector_top.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  adc_x, adc_y, adc_z
// output    out        out_valid / out_stall active, accel_x, accel_y, accel_z
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// From acceptance to a loaded result, each axis passes a multiply state, a
// saturation state and two averaging divisions, each run on the shared
// 16-step restoring divider; then come a decision state and the output load,
// which waits while the output register is not free. The controller is idle
// again in the cycle after the load, and no new input is taken before that.
// Reset is asynchronous and active low; it restores the register defaults and
// clears both averages and the quiet counter.
// A stalled result waits in the output register; the next input transaction is
// taken meanwhile, and its result is loaded once the register frees.
module vibration_activity_detector_top import vad_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ADC_W-1:0]             adc_x,
	input  logic [ADC_W-1:0]             adc_y,
	input  logic [ADC_W-1:0]             adc_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         active,
	output logic signed [ACC_W-1:0]      accel_x,
	output logic signed [ACC_W-1:0]      accel_y,
	output logic signed [ACC_W-1:0]      accel_z,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	cfg_t                       cfg_q;
	cmd_t                       cmd;
	sts_t                       sts;
	logic                       idle;
	logic                       out_load;
	logic                       out_free;
	logic                       in_accept;
	logic [AXES-1:0][ACC_W-1:0] samp;
	logic                       dp_active;

	logic                       out_valid_q;
	logic                       active_q;
	logic [AXES-1:0][ACC_W-1:0] accel_q;

	// The configuration port is always ready. The user must write only while
	// idle; the block does not enforce it. Then no item sees a change midway.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain      <= RST_GAIN;
			cfg_q.offset    <= RST_OFFSET;
			cfg_q.long_len  <= RST_LONG;
			cfg_q.short_len <= RST_SHORT;
			cfg_q.thr       <= RST_THR;
			cfg_q.hold      <= RST_HOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN:   cfg_q.gain      <= cfg_data[GAIN_W-1:0];
				REG_OFFSET: cfg_q.offset    <= $signed(cfg_data[OFS_W-1:0]);
				REG_LONG:   cfg_q.long_len  <= cfg_data[LEN_W-1:0];
				REG_SHORT:  cfg_q.short_len <= cfg_data[LEN_W-1:0];
				REG_THR:    cfg_q.thr       <= cfg_data[THR_W-1:0];
				REG_HOLD:   cfg_q.hold      <= cfg_data[HOLD_W-1:0];
				default: begin
					// Writes to unknown indexes are dropped.
				end
			endcase
		end
	end

	// A new input transaction is taken only while the controller is idle.
	assign in_stall  = !idle;
	assign in_accept = in_valid && !in_stall;

	// The output register is free when empty or when its content leaves now.
	assign out_free = !out_valid_q || !out_stall;

	vad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.out_free  (out_free),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle),
		.out_load  (out_load)
	);

	vad_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.cfg    (cfg_q),
		.adc_x  (adc_x),
		.adc_y  (adc_y),
		.adc_z  (adc_z),
		.samp   (samp),
		.active (dp_active)
	);

	// Output register: holds one finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			active_q <= dp_active;
			accel_q  <= samp;
		end
	end

	assign out_valid = out_valid_q;
	assign active    = active_q;
	assign accel_x   = $signed(accel_q[0]);
	assign accel_y   = $signed(accel_q[1]);
	assign accel_z   = $signed(accel_q[2]);

endmodule
